// ===== rtl/lfm_pkg.sv =====
package lfm_pkg;

    // block geometry
    localparam int unsigned BLOCK_SYMBOLS = 16;
    localparam int unsigned BLK_OFS_W     = $clog2(BLOCK_SYMBOLS);
    localparam int unsigned CNT_W         = $clog2(BLOCK_SYMBOLS + 1);

    // request queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request function codes
    localparam logic [1:0] FUNC_BWT_WR  = 2'd0;
    localparam logic [1:0] FUNC_CKPT_WR = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    // nucleotide codes
    localparam logic [1:0] SYM_A = 2'd0;
    localparam logic [1:0] SYM_T = 2'd3;

    // register map (word index into the APB space)
    localparam int unsigned PADDR_W = 5;
    localparam logic [2:0] REG_SEQ_LENGTH  = 3'd0;
    localparam logic [2:0] REG_PRIMARY_ROW = 3'd1;
    localparam logic [2:0] REG_BASE_A      = 3'd2;
    localparam logic [2:0] REG_BASE_C      = 3'd3;
    localparam logic [2:0] REG_BASE_G      = 3'd4;
    localparam logic [2:0] REG_BASE_T      = 3'd5;

    localparam logic [20:0] SEQ_LENGTH_RESET = 21'd64;

    // configuration seen by front and back
    typedef struct packed {
        logic [20:0]      seq_length;
        logic [20:0]      primary_row;
        logic [3:0][20:0] base_count;
    } lfm_cfg_t;

    // classified request held in the queue
    typedef struct packed {
        logic [1:0]  op;
        logic [17:0] wr_index;
        logic [31:0] wr_data;
        logic [16:0] bwt_addr;
        logic        bwt_ok;
        logic [18:0] ckpt_addr;
        logic        ckpt_ok;
        logic [20:0] row;
        logic [1:0]  sym;
        logic        plus_one;
    } lfm_req_t;

endpackage

// ===== rtl/lfm_front.sv =====
module lfm_front #(
    parameter int unsigned MAX_SYMBOLS = 1048576
) (
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       func,
    input  logic [17:0]      word_index,
    input  logic [31:0]      word_data,
    input  logic [20:0]      row,
    input  logic [1:0]       symbol,
    input  lfm_pkg::lfm_cfg_t cfg,
    output logic             push,
    output lfm_pkg::lfm_req_t req
);
    import lfm_pkg::*;

    localparam int unsigned WORD_COUNT = MAX_SYMBOLS / BLOCK_SYMBOLS;
    localparam int unsigned CKPT_COUNT = WORD_COUNT * 4;

    logic [16:0] blk;
    logic [16:0] ck_blk;
    logic [18:0] ck_idx;
    logic        keep;

    // address and range precompute for the back end
    always_comb
    begin
        blk    = row[20:BLK_OFS_W];
        // bit 3 set: count down from the block's own checkpoint
        ck_blk = row[BLK_OFS_W-1] ? blk : blk - 17'd1;
        ck_idx = {ck_blk, symbol};

        req.op        = func;
        req.wr_index  = word_index;
        req.wr_data   = word_data;
        req.bwt_addr  = blk;
        req.bwt_ok    = 32'(blk) < WORD_COUNT;
        req.ckpt_addr = ck_idx;
        req.ckpt_ok   = (row[BLK_OFS_W-1] || (blk != '0)) && (32'(ck_idx) < CKPT_COUNT);
        req.row       = row;
        req.sym       = symbol;
        req.plus_one  = (symbol == SYM_T) && (row <= cfg.primary_row);
    end

    // drop unused codes and writes beyond a store
    always_comb
    begin
        unique case (func)
            FUNC_BWT_WR:  keep = 32'(word_index) < WORD_COUNT;
            FUNC_CKPT_WR: keep = 32'(word_index) < CKPT_COUNT;
            FUNC_QUERY:   keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign push = start && !busy && keep;

endmodule

// ===== rtl/lfm_queue.sv =====
module lfm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lfm_pkg::lfm_req_t push_req,
    input  logic              pop,
    output logic              head_valid,
    output lfm_pkg::lfm_req_t head,
    output logic              full
);
    import lfm_pkg::*;

    lfm_req_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("request popped from an empty queue");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && !pop) |=> $stable(count_reg))
        else $error("queue fill moved without push or pop");

endmodule

// ===== rtl/lfm_back.sv =====
module lfm_back #(
    parameter int unsigned MAX_SYMBOLS = 1048576
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  lfm_pkg::lfm_req_t head,
    input  lfm_pkg::lfm_cfg_t cfg,
    output logic              pop,
    output logic              done,
    output logic [20:0]       lf_row
);
    import lfm_pkg::*;

    localparam int unsigned WORD_COUNT = MAX_SYMBOLS / BLOCK_SYMBOLS;
    localparam int unsigned CKPT_COUNT = WORD_COUNT * 4;
    localparam int unsigned WAW        = $clog2(WORD_COUNT);
    localparam int unsigned CAW        = $clog2(CKPT_COUNT);

    // BWT words and occurrence checkpoints
    logic [31:0] bwt_mem  [WORD_COUNT];
    logic [20:0] ckpt_mem [CKPT_COUNT];

    logic           is_bwt_wr;
    logic           is_ckpt_wr;
    logic           is_query;
    logic [WAW-1:0] bwt_addr;
    logic [CAW-1:0] ckpt_addr;

    logic [31:0] bwt_rd_reg;
    logic [20:0] ckpt_rd_reg;

    logic        s1_valid_reg;
    logic [20:0] s1_row_reg;
    logic [1:0]  s1_sym_reg;
    logic        s1_bwt_ok_reg;
    logic        s1_ckpt_ok_reg;
    logic        s1_plus_one_reg;

    logic [31:0]              word;
    logic [20:0]              ckpt;
    logic [16:0]              blk;
    logic [16:0]              sl_blk;
    logic                     pos_ok;
    logic                     in_rng;
    logic [1:0]               eff;
    logic [BLOCK_SYMBOLS-1:0] match;
    logic [20:0]              sum_next;
    logic [CNT_W-1:0]         cnt_next;

    logic             s2_valid_reg;
    logic [20:0]      s2_sum_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic             s2_sub_reg;

    logic [20:0] lf_row_next;
    logic        done_reg;
    logic [20:0] lf_row_reg;

    // the back end never stalls: take the head every cycle
    assign pop        = head_valid;
    assign is_bwt_wr  = head_valid && (head.op == FUNC_BWT_WR);
    assign is_ckpt_wr = head_valid && (head.op == FUNC_CKPT_WR);
    assign is_query   = head_valid && (head.op == FUNC_QUERY);

    assign bwt_addr  = is_bwt_wr ? WAW'(32'(head.wr_index)) : WAW'(32'(head.bwt_addr));
    assign ckpt_addr = is_ckpt_wr ? CAW'(32'(head.wr_index)) : CAW'(32'(head.ckpt_addr));

    // single-port BWT memory
    always_ff @(posedge clk)
    begin
        if (is_bwt_wr)
        begin
            bwt_mem[bwt_addr] <= head.wr_data;
        end
        else if (is_query)
        begin
            bwt_rd_reg <= bwt_mem[bwt_addr];
        end
    end

    // single-port checkpoint memory
    always_ff @(posedge clk)
    begin
        if (is_ckpt_wr)
        begin
            ckpt_mem[ckpt_addr] <= head.wr_data[20:0];
        end
        else if (is_query)
        begin
            ckpt_rd_reg <= ckpt_mem[ckpt_addr];
        end
    end

    // stage 1: query context alongside the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg      <= head.row;
        s1_sym_reg      <= head.sym;
        s1_bwt_ok_reg   <= head.bwt_ok;
        s1_ckpt_ok_reg  <= head.ckpt_ok;
        s1_plus_one_reg <= head.plus_one;
    end

    // in-block match count and checkpoint sum
    always_comb
    begin
        word   = s1_bwt_ok_reg ? bwt_rd_reg : '0;
        ckpt   = s1_ckpt_ok_reg ? ckpt_rd_reg : '0;
        blk    = s1_row_reg[20:BLK_OFS_W];
        sl_blk = cfg.seq_length[20:BLK_OFS_W];
        pos_ok = 1'b0;
        in_rng = 1'b0;
        eff    = SYM_A;
        for (int h = 0; h < BLOCK_SYMBOLS; h++)
        begin
            // positions past the sequence end read as A
            pos_ok = (blk < sl_blk) ||
                     ((blk == sl_blk) && (BLK_OFS_W'(h) < cfg.seq_length[BLK_OFS_W-1:0]));
            eff    = pos_ok ? word[2*(BLOCK_SYMBOLS-1-h) +: 2] : SYM_A;
            // upper half: row to block end; lower half: block start to row
            in_rng = s1_row_reg[BLK_OFS_W-1] ?
                     (BLK_OFS_W'(h) >= s1_row_reg[BLK_OFS_W-1:0]) :
                     (BLK_OFS_W'(h) < s1_row_reg[BLK_OFS_W-1:0]);
            match[h] = in_rng && (eff == s1_sym_reg);
        end
        cnt_next = CNT_W'($countones(match));
        sum_next = cfg.base_count[s1_sym_reg] + ckpt + 21'(s1_plus_one_reg);
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sum_reg <= sum_next;
        s2_cnt_reg <= cnt_next;
        s2_sub_reg <= s1_row_reg[BLK_OFS_W-1];
    end

    // final correction, wraps modulo 2^21
    assign lf_row_next = s2_sub_reg ? s2_sum_reg - 21'(s2_cnt_reg) :
                                      s2_sum_reg + 21'(s2_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lf_row_reg <= lf_row_next;
    end

    assign done   = done_reg;
    assign lf_row = lf_row_reg;

    a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        is_query |-> ##3 done_reg)
        else $error("query popped without a result three cycles later");

    a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(is_query, 3))
        else $error("result strobe without a matching query");

endmodule

// ===== rtl/fm_index_lf_mapping_top.sv =====
// Channel    Signals                                        Direction
// ---------  ---------------------------------------------  ---------
// request    start, busy, func, word_index, word_data,      in; busy out
//            row, symbol
// result     done, lf_row                                   out
// config     psel, penable, pwrite, paddr, pwdata,          in/out
//            prdata, pready
//
// One request per cycle sustained while busy is low; a query passes the
// queue write, then the memory read, count and correction stages, and its
// done strobe rises together with lf_row from the correction register.
// Writes and dropped codes give no strobe.
// Reset clears control and registers, seq_length to 64; stores not cleared.
// busy is high only while the four-entry queue is full; the back end drains
// one request each cycle, and the result side has no stall.
module fm_index_lf_mapping_top #(
    parameter int unsigned MAX_SYMBOLS = 1048576
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic [17:0]                 word_index,
    input  logic [31:0]                 word_data,
    input  logic [20:0]                 row,
    input  logic [1:0]                  symbol,
    output logic                        done,
    output logic [20:0]                 lf_row,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lfm_pkg::*;

    logic [20:0]      seq_length_reg;
    logic [20:0]      primary_row_reg;
    logic [3:0][20:0] base_count_reg;
    logic [2:0]       reg_sel;
    logic             cfg_wr;
    lfm_cfg_t         cfg;

    logic     push;
    lfm_req_t push_req;
    logic     head_valid;
    lfm_req_t head;
    logic     pop;
    logic     full;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg  <= SEQ_LENGTH_RESET;
            primary_row_reg <= '0;
            base_count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_SEQ_LENGTH:  seq_length_reg    <= pwdata[20:0];
                REG_PRIMARY_ROW: primary_row_reg   <= pwdata[20:0];
                REG_BASE_A:      base_count_reg[0] <= pwdata[20:0];
                REG_BASE_C:      base_count_reg[1] <= pwdata[20:0];
                REG_BASE_G:      base_count_reg[2] <= pwdata[20:0];
                REG_BASE_T:      base_count_reg[3] <= pwdata[20:0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_sel)
            REG_SEQ_LENGTH:  prdata = 32'(seq_length_reg);
            REG_PRIMARY_ROW: prdata = 32'(primary_row_reg);
            REG_BASE_A:      prdata = 32'(base_count_reg[0]);
            REG_BASE_C:      prdata = 32'(base_count_reg[1]);
            REG_BASE_G:      prdata = 32'(base_count_reg[2]);
            REG_BASE_T:      prdata = 32'(base_count_reg[3]);
            default:         prdata = '0;
        endcase
    end

    assign cfg.seq_length  = seq_length_reg;
    assign cfg.primary_row = primary_row_reg;
    assign cfg.base_count  = base_count_reg;
    assign busy            = full;

    lfm_front #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .func       (func),
        .word_index (word_index),
        .word_data  (word_data),
        .row        (row),
        .symbol     (symbol),
        .cfg        (cfg),
        .push       (push),
        .req        (push_req)
    );

    lfm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (full)
    );

    lfm_back #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .cfg        (cfg),
        .pop        (pop),
        .done       (done),
        .lf_row     (lf_row)
    );

endmodule
